@@ rtl/pws_pkg.sv @@
// Shared constants, waveform codes and the quarter-wave sine table of the
// phase-to-waveform shaper. No dependencies.
package pws_pkg;

    localparam int PHASE_BITS       = 16;
    localparam int SAMPLE_BITS      = 16;
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int SINE_ADDR_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER_BITS   = PHASE_BITS - 2;
    localparam int INTERP_SHIFT   = QUARTER_BITS - SINE_ADDR_BITS;
    localparam int ROM_BITS       = SAMPLE_BITS + 1;
    localparam int FULL_SCALE     = 1 << (SAMPLE_BITS - 1);
    localparam int EVEN_WORDS     = SINE_TABLE_DEPTH / 2 + 1;
    localparam int ODD_WORDS      = SINE_TABLE_DEPTH / 2;

    localparam int ROOT_Z_BITS = 2 * SAMPLE_BITS;
    localparam int ROOT_BITS   = SAMPLE_BITS;
    localparam int ROOT_STAGES = ROOT_BITS / 2;
    localparam int PIPE_STAGES = ROOT_STAGES + 2;

    localparam int WAVE_BITS = 3;
    localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 3'd0;
    localparam logic [WAVE_BITS-1:0] WAVE_SAW      = 3'd1;
    localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 3'd2;
    localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [WAVE_BITS-1:0] WAVE_OVAL     = 3'd4;

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    typedef logic [ROM_BITS-1:0] rom_word_t;
    typedef rom_word_t even_rom_t [EVEN_WORDS];
    typedef rom_word_t odd_rom_t  [ODD_WORDS];

    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // round(F * sin(pi/2 * k / depth)) from a Q30 Taylor series
    function automatic rom_word_t sine_entry(input int k);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        x    = (PI_HALF_Q30 * longint'(k)) >> SINE_ADDR_BITS;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 9; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = div_u64(term, 64'((2 * n) * (2 * n + 1)));
            if ((n & 1) == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        return ROM_BITS'((sum * longint'(FULL_SCALE) + (longint'(1) << 29)) >> 30);
    endfunction

    function automatic even_rom_t build_even_rom();
        even_rom_t r;
        for (int j = 0; j < EVEN_WORDS; j++)
        begin
            r[j] = sine_entry(2 * j);
        end
        return r;
    endfunction

    function automatic odd_rom_t build_odd_rom();
        odd_rom_t r;
        for (int j = 0; j < ODD_WORDS; j++)
        begin
            r[j] = sine_entry(2 * j + 1);
        end
        return r;
    endfunction

    localparam even_rom_t SINE_EVEN = build_even_rom();
    localparam odd_rom_t  SINE_ODD  = build_odd_rom();

endpackage

@@ rtl/pws_stream_if.sv @@
// Valid/ready stream interfaces for phase requests and sample results.
// Depends on pws_pkg for field widths.
interface pws_phase_if;
    import pws_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [PHASE_BITS-1:0] phase;
    modport source (output valid, output phase, input ready);
    modport sink   (input valid, input phase, output ready);
endinterface

interface pws_sample_if;
    import pws_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ rtl/phase_to_waveform_shaper_unit.sv @@
// Top level of the phase-to-waveform shaper: pipelined sine, saw, square,
// triangle and oval shaping. Depends on pws_pkg and pws_stream_if.
//
// Usage:
//   phase_ch carries one phase request per handshake, an unsigned fraction of
//   a full turn; sample_ch returns one signed Q1.15 sample per request, in
//   order. cfg_we/cfg_wdata write the waveform selector (0 sine, 1 sawtooth,
//   2 square, 3 triangle, 4 oval, other codes give 0); write it only while no
//   request is in flight.
//   Throughput: one request per cycle while a stage is free or the receiver takes a sample.
//   The 10 stages are set by the 16-step square root of the oval shape, two
//   result bits per stage, plus one stage in front for the phase decode and
//   product and one behind for the final select and saturation. The sine
//   table is read from two banks (even and odd entries) in stage one.
//   Reset empties the pipeline and selects sine.
//   When the receiver stalls, occupied stages hold; empty stages ahead of a
//   stalled item still fill, so phase_ch stays ready while any stage is free.
module phase_to_waveform_shaper_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pws_pkg::WAVE_BITS-1:0]    cfg_wdata,
    pws_phase_if.sink                        phase_ch,
    pws_sample_if.source                     sample_ch
);
    import pws_pkg::*;

    localparam int VAL_BITS   = SAMPLE_BITS + 2;
    localparam int FINAL_BITS = ROM_BITS + 2;
    localparam int PROD_BITS  = 2 * PHASE_BITS - 1;
    localparam int FRAC_PROD_BITS = ROM_BITS + INTERP_SHIFT;

    localparam logic [QUARTER_BITS:0]  QUARTER_POS = (QUARTER_BITS + 1)'(1) << QUARTER_BITS;
    localparam logic [PHASE_BITS-1:0]  HALF        = PHASE_BITS'(1) << (PHASE_BITS - 1);
    localparam logic [PHASE_BITS-1:0]  QUARTER     = PHASE_BITS'(1) << (PHASE_BITS - 2);
    localparam logic [PHASE_BITS-1:0]  THREE_Q     = HALF + QUARTER;
    localparam logic signed [VAL_BITS-1:0]   FS_VAL  = VAL_BITS'(FULL_SCALE);
    localparam logic signed [FINAL_BITS-1:0] MAX_V   = FINAL_BITS'(FULL_SCALE - 1);
    localparam logic signed [FINAL_BITS-1:0] MIN_V   = -FINAL_BITS'(FULL_SCALE);
    localparam logic [FRAC_PROD_BITS-1:0]    ROUND_HALF =
        FRAC_PROD_BITS'(1) << (INTERP_SHIFT - 1);

    typedef struct packed {
        logic [WAVE_BITS-1:0]        sel;
        logic                        neg;
        logic signed [VAL_BITS-1:0]  val;
        logic [INTERP_SHIFT-1:0]     frac;
        logic [SINE_ADDR_BITS-1:0]   eaddr;
        logic [SINE_ADDR_BITS-2:0]   oaddr;
        logic                        odd;
        logic [ROM_BITS-1:0]         ev;
        logic [ROM_BITS-1:0]         od;
        logic [ROM_BITS-1:0]         lo;
        logic [ROM_BITS-1:0]         diff;
        logic [ROM_BITS-1:0]         mag;
        logic [ROOT_Z_BITS-1:0]      rem;
        logic [ROOT_Z_BITS-1:0]      res;
        logic signed [SAMPLE_BITS-1:0] smp;
    } stage_t;

    typedef struct packed {
        logic [ROOT_Z_BITS-1:0] rem;
        logic [ROOT_Z_BITS-1:0] res;
    } root_t;

    function automatic root_t root_step(input root_t r, input int j);
        logic [ROOT_Z_BITS-1:0] bitv;
        logic [ROOT_Z_BITS-1:0] trial;
        root_t                  o;
        bitv  = ROOT_Z_BITS'(1) << (2 * j);
        trial = r.res + bitv;
        o     = r;
        if (r.rem >= trial)
        begin
            o.rem = r.rem - trial;
            o.res = (r.res >> 1) + bitv;
        end
        else
        begin
            o.res = r.res >> 1;
        end
        return o;
    endfunction

    logic [WAVE_BITS-1:0]   waveform_reg;
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;
    logic [PIPE_STAGES-1:0] adv;
    stage_t                 st_reg  [PIPE_STAGES];
    stage_t                 st_next [PIPE_STAGES];

    logic [PHASE_BITS-1:0]     p;
    logic [1:0]                quad;
    logic [QUARTER_BITS:0]     pos;
    logic [SINE_ADDR_BITS:0]   idx;
    logic [SINE_ADDR_BITS:0]   idx_p1;
    logic [PHASE_BITS-2:0]     w;
    logic [PHASE_BITS-1:0]     hw;
    logic [PROD_BITS-1:0]      prod;
    logic [PHASE_BITS-1:0]     d_q;
    logic [PHASE_BITS-1:0]     d_3q;

    always_comb
    begin
        p      = phase_ch.phase;
        quad   = p[PHASE_BITS-1 -: 2];
        pos    = quad[0] ? (QUARTER_POS - {1'b0, p[QUARTER_BITS-1:0]})
                         : {1'b0, p[QUARTER_BITS-1:0]};
        idx    = pos[QUARTER_BITS:INTERP_SHIFT];
        idx_p1 = idx + 1'b1;
        w      = p[PHASE_BITS-2:0];
        hw     = HALF - {1'b0, w};
        prod   = PROD_BITS'(w) * PROD_BITS'(hw);
        d_q    = p - QUARTER;
        d_3q   = p - THREE_Q;
    end

    always_comb
    begin
        adv[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || sample_ch.ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next = {vld_reg[PIPE_STAGES-2:0], phase_ch.valid};
    end

    assign phase_ch.ready   = adv[0];
    assign sample_ch.valid  = vld_reg[PIPE_STAGES-1];
    assign sample_ch.sample = st_reg[PIPE_STAGES-1].smp;

    always_comb
    begin
        root_t                         r;
        logic [ROM_BITS-1:0]           hi;
        logic [FRAC_PROD_BITS-1:0]     fprod;
        logic signed [FINAL_BITS-1:0]  v;
        stage_t                        s;

        st_next[0] = st_reg[0];
        for (int k = 1; k < PIPE_STAGES; k++)
        begin
            st_next[k] = st_reg[k-1];
        end

        // decode phase, oval product, linear shapes
        st_next[0].sel   = waveform_reg;
        st_next[0].neg   = (waveform_reg == WAVE_OVAL) ? (p > HALF) : quad[1];
        st_next[0].frac  = pos[INTERP_SHIFT-1:0];
        st_next[0].eaddr = idx_p1[SINE_ADDR_BITS:1];
        st_next[0].oaddr = idx[SINE_ADDR_BITS-1:1];
        st_next[0].odd   = idx[0];
        st_next[0].rem   = {prod[ROOT_Z_BITS-3:0], 2'b00};
        st_next[0].res   = '0;
        unique case (waveform_reg)
            WAVE_SAW:
            begin
                st_next[0].val = $signed({2'b00, p ^ HALF}) - FS_VAL;
            end
            WAVE_SQUARE:
            begin
                st_next[0].val = (p < HALF) ? FS_VAL : -FS_VAL;
            end
            WAVE_TRIANGLE:
            begin
                if (p < QUARTER)
                begin
                    st_next[0].val = $signed({1'b0, p, 1'b0});
                end
                else if (p < THREE_Q)
                begin
                    st_next[0].val = FS_VAL - $signed({1'b0, d_q, 1'b0});
                end
                else
                begin
                    st_next[0].val = $signed({1'b0, d_3q, 1'b0}) - FS_VAL;
                end
            end
            default:
            begin
                st_next[0].val = '0;
            end
        endcase

        // square root, two result bits per stage
        for (int k = 1; k <= ROOT_STAGES; k++)
        begin
            r.rem = st_reg[k-1].rem;
            r.res = st_reg[k-1].res;
            r = root_step(r, ROOT_BITS - 2 * k + 1);
            r = root_step(r, ROOT_BITS - 2 * k);
            st_next[k].rem = r.rem;
            st_next[k].res = r.res;
        end

        // sine table banks, then interpolate
        st_next[1].ev = SINE_EVEN[st_reg[0].eaddr];
        st_next[1].od = SINE_ODD[st_reg[0].oaddr];

        st_next[2].lo   = st_reg[1].odd ? st_reg[1].od : st_reg[1].ev;
        hi              = st_reg[1].odd ? st_reg[1].ev : st_reg[1].od;
        st_next[2].diff = (hi < st_next[2].lo) ? '0 : hi - st_next[2].lo;

        fprod          = FRAC_PROD_BITS'(st_reg[2].diff) * FRAC_PROD_BITS'(st_reg[2].frac);
        fprod          = (fprod + ROUND_HALF) >> INTERP_SHIFT;
        st_next[3].mag = fprod[ROM_BITS-1:0];

        st_next[4].mag = st_reg[3].lo + st_reg[3].mag;

        // select, negate, saturate
        s = st_reg[PIPE_STAGES-2];
        unique case (s.sel)
            WAVE_SINE:
            begin
                v = s.neg ? -$signed({2'b00, s.mag}) : $signed({2'b00, s.mag});
            end
            WAVE_OVAL:
            begin
                v = s.neg ? -$signed({2'b00, s.res[ROM_BITS-1:0]})
                          :  $signed({2'b00, s.res[ROM_BITS-1:0]});
            end
            WAVE_SAW, WAVE_SQUARE, WAVE_TRIANGLE:
            begin
                v = {s.val[VAL_BITS-1], s.val};
            end
            default:
            begin
                v = '0;
            end
        endcase
        if (v > MAX_V)
        begin
            v = MAX_V;
        end
        else if (v < MIN_V)
        begin
            v = MIN_V;
        end
        st_next[PIPE_STAGES-1].smp = v[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg <= WAVE_SINE;
            vld_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                waveform_reg <= cfg_wdata;
            end
            for (int k = 0; k < PIPE_STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < PIPE_STAGES; k++)
        begin
            if (adv[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

endmodule

@@ rtl/pws_checker.sv @@
// Port-level checks for the phase-to-waveform shaper and their bind.
// Depends on pws_pkg and phase_to_waveform_shaper_unit.
module pws_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [pws_pkg::SAMPLE_BITS-1:0] out_sample
);
    import pws_pkg::*;

    localparam int CNT_BITS = $clog2(PIPE_STAGES + 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(PIPE_STAGES);

    logic [CNT_BITS-1:0] inflight_reg;
    logic [CNT_BITS-1:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg + CNT_BITS'(in_valid && in_ready)
                      - CNT_BITS'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample))
        else $error("stalled sample changed or dropped");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != '0)
        else $error("sample without an outstanding request");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= FULL_CNT)
        else $error("more requests in flight than pipeline stages");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (inflight_reg != FULL_CNT || out_ready))
        else $error("ready does not track free pipeline stages");

endmodule

bind phase_to_waveform_shaper_unit pws_checker u_pws_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (phase_ch.valid),
    .in_ready   (phase_ch.ready),
    .out_valid  (sample_ch.valid),
    .out_ready  (sample_ch.ready),
    .out_sample (sample_ch.sample)
);
